>>> hdl/ipid_pkg.sv
// Shared types and constants for the incremental PID drive controller.
`default_nettype none

package ipid_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned ErrW = DataW + 1;
  localparam int unsigned DeltaW = DataW + 2;
  localparam int unsigned Delta2W = DataW + 3;
  localparam int unsigned FracW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegGainP = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDeadBand = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutMax = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOutMin = 3'd5;

  typedef struct packed {
    logic [DataW-1:0]        gain_p;
    logic [DataW-1:0]        gain_i;
    logic [DataW-1:0]        gain_d;
    logic [DataW-1:0]        dead_band;
    logic signed [DataW-1:0] out_max;
    logic signed [DataW-1:0] out_min;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/ipid_core.sv
// Error differences, gain products, dead band test and clamp for one sample.
`default_nettype none

module ipid_core (
  input  ipid_pkg::cfg_t                          cfg,
  input  logic signed [ipid_pkg::DataW-1:0]       target,
  input  logic signed [ipid_pkg::DataW-1:0]       measured,
  input  logic signed [ipid_pkg::ErrW-1:0]        last_error,
  input  logic signed [ipid_pkg::DeltaW-1:0]      last_delta,
  input  logic signed [ipid_pkg::DataW-1:0]       held_drive,
  output logic signed [ipid_pkg::ErrW-1:0]        err,
  output logic signed [ipid_pkg::DeltaW-1:0]      delta,
  output logic signed [ipid_pkg::DataW-1:0]       drive_next
);

  localparam int unsigned ProdW = ipid_pkg::Delta2W + ipid_pkg::DataW + 3;
  localparam int unsigned IncrW = ProdW - ipid_pkg::FracW;
  localparam int unsigned AccW = IncrW + 1;

  logic signed [ipid_pkg::Delta2W-1:0] delta2;
  logic [ipid_pkg::ErrW-1:0]           mag;
  logic                                apply;
  logic signed [ipid_pkg::DataW:0]     gp;
  logic signed [ipid_pkg::DataW:0]     gi;
  logic signed [ipid_pkg::DataW:0]     gd;
  logic signed [ProdW-1:0]             prod_p;
  logic signed [ProdW-1:0]             prod_i;
  logic signed [ProdW-1:0]             prod_d;
  logic signed [ProdW-1:0]             sum;
  logic signed [IncrW-1:0]             incr;
  logic signed [AccW-1:0]              acc;
  logic signed [AccW-1:0]              max_ext;
  logic signed [AccW-1:0]              min_ext;

  assign err    = $signed({target[ipid_pkg::DataW-1], target})
                - $signed({measured[ipid_pkg::DataW-1], measured});
  assign delta  = $signed({err[ipid_pkg::ErrW-1], err})
                - $signed({last_error[ipid_pkg::ErrW-1], last_error});
  assign delta2 = $signed({delta[ipid_pkg::DeltaW-1], delta})
                - $signed({last_delta[ipid_pkg::DeltaW-1], last_delta});

  assign mag   = err[ipid_pkg::ErrW-1] ? ({ipid_pkg::ErrW{1'b0}} - err) : err;
  assign apply = mag >= {1'b0, cfg.dead_band};

  assign gp = $signed({1'b0, cfg.gain_p});
  assign gi = $signed({1'b0, cfg.gain_i});
  assign gd = $signed({1'b0, cfg.gain_d});

  assign prod_p = ProdW'(gp) * ProdW'(delta);
  assign prod_i = ProdW'(gi) * ProdW'(err);
  assign prod_d = ProdW'(gd) * ProdW'(delta2);
  assign sum    = prod_p + prod_i + prod_d;
  assign incr   = IncrW'(sum >>> ipid_pkg::FracW);

  assign max_ext = AccW'(cfg.out_max);
  assign min_ext = AccW'(cfg.out_min);

  always_comb begin
    acc = AccW'(held_drive);
    if (apply) begin
      acc = acc + AccW'(incr);
    end
    if (acc >= max_ext) begin
      drive_next = cfg.out_max;
    end else if (acc <= min_ext) begin
      drive_next = cfg.out_min;
    end else begin
      drive_next = acc[ipid_pkg::DataW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/incremental_pid_deadband_clamp_unit.sv
// Top level of the incremental PID controller with dead band and output clamp.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  target, measured
//   out      output     out_valid / out_stall drive
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One sample per cycle sustained while out_stall is low. A sample sits in the input
// register, then the single-pass update of the controller state loads the result
// register, which holds drive. The output register frees the input side while a
// result waits; in_stall rises only when both registers are full and
// out_stall is high. rst clears the controller state and loads register defaults.
`default_nettype none

module incremental_pid_deadband_clamp_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [ipid_pkg::DataW-1:0]       target,
  input  logic signed [ipid_pkg::DataW-1:0]       measured,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ipid_pkg::DataW-1:0]       drive,
  input  logic                                    cfg_we,
  input  logic [ipid_pkg::CfgIdxW-1:0]            cfg_index,
  input  logic [ipid_pkg::DataW-1:0]              cfg_data
);

  ipid_pkg::cfg_t                       cfg;
  logic                                 s1_valid;
  logic signed [ipid_pkg::DataW-1:0]    s1_target;
  logic signed [ipid_pkg::DataW-1:0]    s1_measured;
  logic signed [ipid_pkg::ErrW-1:0]     last_error;
  logic signed [ipid_pkg::DeltaW-1:0]   last_delta;
  logic signed [ipid_pkg::DataW-1:0]    held_drive;
  logic signed [ipid_pkg::ErrW-1:0]     err;
  logic signed [ipid_pkg::DeltaW-1:0]   delta;
  logic signed [ipid_pkg::DataW-1:0]    drive_next;
  logic                                 advance;
  logic                                 in_take;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p    <= '0;
      cfg.gain_i    <= '0;
      cfg.gain_d    <= '0;
      cfg.dead_band <= '0;
      cfg.out_max   <= 16'sh7fff;
      cfg.out_min   <= 16'sh8000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipid_pkg::RegGainP:    cfg.gain_p    <= cfg_data;
        ipid_pkg::RegGainI:    cfg.gain_i    <= cfg_data;
        ipid_pkg::RegGainD:    cfg.gain_d    <= cfg_data;
        ipid_pkg::RegDeadBand: cfg.dead_band <= cfg_data;
        ipid_pkg::RegOutMax:   cfg.out_max   <= $signed(cfg_data);
        ipid_pkg::RegOutMin:   cfg.out_min   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_target   <= target;
      s1_measured <= measured;
    end
  end

  ipid_core u_core (
    .cfg        (cfg),
    .target     (s1_target),
    .measured   (s1_measured),
    .last_error (last_error),
    .last_delta (last_delta),
    .held_drive (held_drive),
    .err        (err),
    .delta      (delta),
    .drive_next (drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      last_delta <= '0;
      held_drive <= '0;
    end else if (advance) begin
      last_error <= err;
      last_delta <= delta;
      held_drive <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive <= drive_next;
    end
  end

endmodule

`default_nettype wire
